/* rtl/core/lflm_pkg.sv */
// ----------------------------------------------------------------------------
// Linked free list manager package
// Shared constants, command codes and the records passed between the units.
// ----------------------------------------------------------------------------
`default_nettype none

package lflm_pkg;

    localparam int NUM_BLOCKS = 1024;
    localparam int IDX_W      = $clog2(NUM_BLOCKS);
    localparam int PTR_W      = IDX_W + 1;
    localparam int LEN_W      = 11;
    localparam int CNT_W      = 11;
    localparam int BLK_W      = 10;
    localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(NUM_BLOCKS);

    typedef enum logic [1:0] {
        CMD_PUSH       = 2'd0,
        CMD_PUSH_RANGE = 2'd1,
        CMD_POP        = 2'd2,
        CMD_POP_RANGE  = 2'd3
    } t_cmd;

    // One queued operation: single pushes and pops become runs of one block.
    // A run pop ends the detached run with a null link; a single pop does not.
    typedef struct packed {
        logic             is_pop;
        logic             end_null;
        logic [BLK_W-1:0] first;
        logic [BLK_W-1:0] last;
        logic [LEN_W-1:0] len;
    } t_op;

    typedef struct packed {
        logic [BLK_W-1:0] got_first;
        logic [BLK_W-1:0] got_last;
        logic [CNT_W-1:0] free_count;
        logic             list_empty;
        logic             fault;
    } t_result;

endpackage

`default_nettype wire

/* rtl/core/lflm_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module lflm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

/* rtl/core/lflm_front.sv */
// ----------------------------------------------------------------------------
// Free list front end
// Accepts command beats, turns them into run operations and queues them.
// ----------------------------------------------------------------------------
`default_nettype none

module lflm_front (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cmd_valid,
    output logic                              o_cmd_ready,
    input  wire lflm_pkg::t_cmd               i_cmd,
    input  wire logic [lflm_pkg::BLK_W-1:0]   i_first_block,
    input  wire logic [lflm_pkg::BLK_W-1:0]   i_last_block,
    input  wire logic [lflm_pkg::LEN_W-1:0]   i_run_length,
    output logic                              o_op_valid,
    input  wire logic                         i_op_ready,
    output lflm_pkg::t_op                     o_op
);

    lflm_pkg::t_op r_queue [2];
    logic          r_wr_ptr;
    logic          r_rd_ptr;
    logic [1:0]    r_fill;
    lflm_pkg::t_op n_op;
    logic          push_en;
    logic          pop_en;

    always_comb begin
        n_op.is_pop   = 1'b0;
        n_op.end_null = 1'b0;
        n_op.first    = i_first_block;
        n_op.last     = i_last_block;
        n_op.len      = i_run_length;
        case (i_cmd)
            lflm_pkg::CMD_PUSH: begin
                n_op.last = i_first_block;
                n_op.len  = lflm_pkg::LEN_W'(1);
            end
            lflm_pkg::CMD_PUSH_RANGE: begin
            end
            lflm_pkg::CMD_POP: begin
                n_op.is_pop = 1'b1;
                n_op.len    = lflm_pkg::LEN_W'(1);
            end
            lflm_pkg::CMD_POP_RANGE: begin
                n_op.is_pop   = 1'b1;
                n_op.end_null = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign o_cmd_ready = (r_fill != 2'd2);
    assign o_op_valid  = (r_fill != 2'd0);
    assign o_op        = r_queue[r_rd_ptr];
    assign push_en     = i_cmd_valid && o_cmd_ready;
    assign pop_en      = o_op_valid && i_op_ready;

    always_ff @(posedge i_clk) begin
        if (push_en) begin
            r_queue[r_wr_ptr] <= n_op;
        end
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            if (push_en) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop_en) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (push_en && !pop_en) begin
                r_fill <= r_fill + 2'd1;
            end else if (pop_en && !push_en) begin
                r_fill <= r_fill - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/core/lflm_back.sv */
// ----------------------------------------------------------------------------
// Free list back end
// Holds the head and count, walks the link store and registers each result.
// ----------------------------------------------------------------------------
`default_nettype none

module lflm_back (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_op_valid,
    output logic                              o_op_ready,
    input  wire lflm_pkg::t_op                i_op,
    output logic                              o_res_valid,
    input  wire logic                         i_res_ready,
    output lflm_pkg::t_result                 o_res
);

    typedef enum logic {
        ST_IDLE,
        ST_WALK
    } t_state;

    t_state                       r_state, n_state;
    logic [lflm_pkg::PTR_W-1:0]   r_head, n_head;
    logic [lflm_pkg::CNT_W-1:0]   r_free, n_free;
    logic [lflm_pkg::IDX_W-1:0]   r_end, n_end;
    logic [lflm_pkg::IDX_W-1:0]   r_first, n_first;
    logic [lflm_pkg::LEN_W-1:0]   r_remain, n_remain;
    logic [lflm_pkg::LEN_W-1:0]   r_len, n_len;
    logic                         r_end_null, n_end_null;
    logic                         r_res_valid, n_res_valid;
    lflm_pkg::t_result            r_res, n_res;

    logic                         we;
    logic [lflm_pkg::IDX_W-1:0]   waddr;
    logic [lflm_pkg::PTR_W-1:0]   wdata;
    logic                         re;
    logic [lflm_pkg::IDX_W-1:0]   raddr;
    logic [lflm_pkg::PTR_W-1:0]   rdata;

    logic                         slot_free;
    logic                         start;
    logic [lflm_pkg::CNT_W:0]     push_sum;
    logic                         head_null;
    logic                         push_fault;
    logic                         pop_fault;

    lflm_ram #(
        .WIDTH (lflm_pkg::PTR_W),
        .DEPTH (lflm_pkg::NUM_BLOCKS)
    ) u_link_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign slot_free  = !r_res_valid || i_res_ready;
    assign start      = (r_state == ST_IDLE) && i_op_valid && slot_free;
    assign o_op_ready = start;
    assign head_null  = (r_head >= lflm_pkg::NULL_PTR);
    assign push_sum   = {1'b0, r_free} + (lflm_pkg::CNT_W + 1)'(i_op.len);
    assign push_fault = (i_op.len == '0) ||
                        (push_sum > (lflm_pkg::CNT_W + 1)'(lflm_pkg::NUM_BLOCKS));
    assign pop_fault  = (i_op.len == '0) ||
                        (i_op.len > lflm_pkg::LEN_W'(r_free)) || head_null;

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_free      = r_free;
        n_end       = r_end;
        n_first     = r_first;
        n_remain    = r_remain;
        n_len       = r_len;
        n_end_null  = r_end_null;
        n_res_valid = r_res_valid && !i_res_ready;
        n_res       = r_res;
        we          = 1'b0;
        waddr       = r_end;
        wdata       = lflm_pkg::NULL_PTR;
        re          = 1'b0;
        raddr       = r_head[lflm_pkg::IDX_W-1:0];

        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    if (!i_op.is_pop) begin
                        n_res_valid = 1'b1;
                        n_res       = '0;
                        if (push_fault) begin
                            n_res.fault = 1'b1;
                        end else begin
                            we     = 1'b1;
                            waddr  = i_op.last;
                            wdata  = r_head;
                            n_head = lflm_pkg::PTR_W'(i_op.first);
                            n_free = push_sum[lflm_pkg::CNT_W-1:0];
                        end
                        n_res.free_count = n_free;
                        n_res.list_empty = (n_head >= lflm_pkg::NULL_PTR);
                    end else if (pop_fault) begin
                        n_res_valid      = 1'b1;
                        n_res            = '0;
                        n_res.fault      = 1'b1;
                        n_res.free_count = r_free;
                        n_res.list_empty = head_null;
                    end else begin
                        re         = 1'b1;
                        n_end      = r_head[lflm_pkg::IDX_W-1:0];
                        n_first    = r_head[lflm_pkg::IDX_W-1:0];
                        n_remain   = i_op.len - lflm_pkg::LEN_W'(1);
                        n_len      = i_op.len;
                        n_end_null = i_op.end_null;
                        n_state    = ST_WALK;
                    end
                end
            end
            ST_WALK: begin
                if (r_remain == '0) begin
                    we          = r_end_null;
                    n_head      = rdata;
                    n_free      = r_free - lflm_pkg::CNT_W'(r_len);
                    n_res_valid = 1'b1;
                    n_res.got_first  = r_first;
                    n_res.got_last   = r_end;
                    n_res.free_count = n_free;
                    n_res.list_empty = (rdata >= lflm_pkg::NULL_PTR);
                    n_res.fault      = 1'b0;
                    n_state     = ST_IDLE;
                end else if (rdata >= lflm_pkg::NULL_PTR) begin
                    n_res_valid      = 1'b1;
                    n_res            = '0;
                    n_res.fault      = 1'b1;
                    n_res.free_count = r_free;
                    n_res.list_empty = head_null;
                    n_state          = ST_IDLE;
                end else begin
                    re       = 1'b1;
                    raddr    = rdata[lflm_pkg::IDX_W-1:0];
                    n_end    = rdata[lflm_pkg::IDX_W-1:0];
                    n_remain = r_remain - lflm_pkg::LEN_W'(1);
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_end      <= n_end;
        r_first    <= n_first;
        r_remain   <= n_remain;
        r_len      <= n_len;
        r_end_null <= n_end_null;
        r_res      <= n_res;
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_head      <= lflm_pkg::NULL_PTR;
            r_free      <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_free      <= n_free;
            r_res_valid <= n_res_valid;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

`default_nettype wire

/* rtl/core/linked_free_list_manager.sv */
// ----------------------------------------------------------------------------
// Linked free list manager
// LIFO free list of block indices chained through a link store memory.
// A push, or a pop refused at the outset, is done in the IDLE state. A pop
// walks the link store in the WALK state, one link per cycle, through its
// single read port, and takes no new operation until the walk ends. Pushes
// are taken one per cycle while each result beat is taken as it is offered.
// Reset empties the list (head null, count zero); the link store is not
// cleared and no start-up pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module linked_free_list_manager (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,  // first_block[9:0], last_block[19:10], run_length[30:20]
    input  wire logic [1:0]  s_tuser,  // cmd[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,  // got_first[9:0], got_last[19:10], free_count[30:20]
    output logic [1:0]       m_tuser   // list_empty[0], fault[1]
);

    logic              op_valid;
    logic              op_ready;
    lflm_pkg::t_op     op;
    lflm_pkg::t_result res;

    lflm_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (s_tvalid),
        .o_cmd_ready   (s_tready),
        .i_cmd         (lflm_pkg::t_cmd'(s_tuser)),
        .i_first_block (s_tdata[9:0]),
        .i_last_block  (s_tdata[19:10]),
        .i_run_length  (s_tdata[30:20]),
        .o_op_valid    (op_valid),
        .i_op_ready    (op_ready),
        .o_op          (op)
    );

    lflm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op_valid  (op_valid),
        .o_op_ready  (op_ready),
        .i_op        (op),
        .o_res_valid (m_tvalid),
        .i_res_ready (m_tready),
        .o_res       (res)
    );

    assign m_tdata = {1'b0, res.free_count, res.got_last, res.got_first};
    assign m_tuser = {res.fault, res.list_empty};

endmodule

`default_nettype wire
